[hdl/icq_pkg.sv]
`default_nettype none

package icq_pkg;

    localparam int FRAC_BITS = 16;
    localparam int U_BITS    = 30;                   // fraction bits of u = t/T
    localparam int U_W       = U_BITS + 1;           // u ranges up to 1.0
    localparam int T_W       = 31;                   // elapsed and blend time
    localparam int D_W       = T_W + 1;              // divider remainder
    localparam int V_W       = 32;                   // signed value width
    localparam int X0_W      = V_W + 1;              // start minus target
    localparam int PROD_W    = V_W + T_W;            // v0 * T
    localparam int W_W       = PROD_W - FRAC_BITS;   // v0 * T in value units
    localparam int AL_W      = W_W + 5;              // a0 * T^2
    localparam int COEF_W    = AL_W + 4;             // polynomial coefficients
    localparam int MAG_W     = COEF_W - 1;
    localparam int HI_W      = MAG_W - U_BITS;
    localparam int HP_W      = HI_W + U_W;
    localparam int LPF_W     = U_BITS + U_W;
    localparam int SUM_W     = COEF_W + 2;
    localparam int NTERM     = 5;                    // terms in u .. u^5
    localparam int NPOW      = NTERM - 1;            // power stages

    localparam logic [U_W-1:0] U_ONE   = U_W'(1) << U_BITS;
    localparam logic [V_W-1:0] VAL_MAX = {1'b0, {(V_W-1){1'b1}}};
    localparam logic [V_W-1:0] VAL_MIN = {1'b1, {(V_W-1){1'b0}}};
    localparam logic [T_W-1:0] BLEND_RESET = T_W'(1) << FRAC_BITS;

    typedef enum logic [1:0] {
        REG_START    = 2'd0,
        REG_TARGET   = 2'd1,
        REG_VELOCITY = 2'd2,
        REG_BLEND    = 2'd3
    } icq_reg_t;

    // coefficient i multiplies u^(i+1), held as sign and magnitude
    typedef struct packed {
        logic [NTERM-1:0]                neg;
        logic [NTERM-1:0][HI_W-1:0]      hi;
        logic [NTERM-1:0][U_BITS-1:0]    lo;
        logic [X0_W:0]                   two_x0;
        logic                            x0_zero;
    } icq_coef_t;

endpackage

`default_nettype wire

[hdl/inertialization_quintic_curve_top.sv]
// channel   direction  handshake            payload
// ------    ---------  ---------            -------
// input     in         start / busy         elapsed_time
// result    out        done (one cycle)     curve_value, finished, saturated
// config    in/out     APB psel/penable     start, target, velocity, blend time
//
// One item enters every cycle; busy stays low. The result strobe done comes
// after the item has passed the one-bit-per-stage divider for u = t/T, then
// the 10 stages of powers, products and sums.
// Reset clears the registers to start 0, target 0, velocity 0, blend time 1.0
// and empties the pipeline. The receiver cannot stall; nothing holds results.
// Coefficients settle once a register write has passed the stages of icq_coef.
`default_nettype none

module inertialization_quintic_curve_top
    import icq_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            psel,
    input  wire logic            penable,
    input  wire logic            pwrite,
    input  wire logic [3:0]      paddr,
    input  wire logic [31:0]     pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  wire logic            start,
    output logic                 busy,
    input  wire logic [T_W-1:0]  elapsed_time,
    output logic                 done,
    output logic [V_W-1:0]       curve_value,
    output logic                 finished,
    output logic                 saturated
);

    logic [V_W-1:0] start_reg, target_reg, velocity_reg;
    logic [T_W-1:0] blend_reg;
    logic           wr_en;
    icq_reg_t       reg_sel;

    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = icq_reg_t'(paddr[3:2]);
    assign pready  = 1'b1;
    assign busy    = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg    <= '0;
            target_reg   <= '0;
            velocity_reg <= '0;
            blend_reg    <= BLEND_RESET;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_START:    start_reg    <= pwdata;
                REG_TARGET:   target_reg   <= pwdata;
                REG_VELOCITY: velocity_reg <= pwdata;
                REG_BLEND:    blend_reg    <= pwdata[T_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_START:    prdata = start_reg;
            REG_TARGET:   prdata = target_reg;
            REG_VELOCITY: prdata = velocity_reg;
            REG_BLEND:    prdata = {1'b0, blend_reg};
            default:      prdata = '0;
        endcase
    end

    logic           u_valid, u_over;
    logic [U_W-1:0] u;
    icq_coef_t      coef;

    icq_div u_div (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .elapsed_time (elapsed_time),
        .blend_time   (blend_reg),
        .u_valid      (u_valid),
        .u            (u),
        .u_over       (u_over)
    );

    icq_coef u_coef (
        .clk            (clk),
        .rst_n          (rst_n),
        .start_value    (start_reg),
        .target_value   (target_reg),
        .start_velocity (velocity_reg),
        .blend_time     (blend_reg),
        .coef           (coef)
    );

    icq_poly u_poly (
        .clk          (clk),
        .rst_n        (rst_n),
        .u_valid      (u_valid),
        .u            (u),
        .u_over       (u_over),
        .coef         (coef),
        .target_value (target_reg),
        .done         (done),
        .curve_value  (curve_value),
        .finished     (finished),
        .saturated    (saturated)
    );

endmodule

`default_nettype wire

[hdl/icq_div.sv]
`default_nettype none

module icq_div
    import icq_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire logic [T_W-1:0]  elapsed_time,
    input  wire logic [T_W-1:0]  blend_time,
    output logic                 u_valid,
    output logic [U_W-1:0]       u,
    output logic                 u_over
);

    logic [D_W-1:0] rem_reg  [U_W];
    logic [D_W-1:0] rem_next [U_W];
    logic [U_W-1:0] quo_reg  [U_W];
    logic [U_W-1:0] quo_next [U_W];
    logic [U_W-1:0] vld_reg;
    logic [U_W-1:0] ovr_reg;
    logic           ovr_in;

    assign ovr_in = (elapsed_time > blend_time) || (blend_time == '0);

    // one quotient bit per stage, msb first
    for (genvar j = 0; j < U_W; j++) begin : g_stage
        logic [D_W-1:0] cand;
        logic [D_W-1:0] diff;
        logic [U_W-1:0] qprev;
        logic           ge;

        if (j == 0) begin : g_first
            assign cand  = {1'b0, elapsed_time};
            assign qprev = '0;
        end
        else begin : g_rest
            assign cand  = {rem_reg[j-1][D_W-2:0], 1'b0};
            assign qprev = quo_reg[j-1];
        end

        assign ge          = cand >= {1'b0, blend_time};
        assign diff        = cand - {1'b0, blend_time};
        assign rem_next[j] = ge ? diff : cand;
        assign quo_next[j] = {qprev[U_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            ovr_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[U_W-2:0], start};
            ovr_reg <= {ovr_reg[U_W-2:0], ovr_in};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < U_W; k++)
        begin
            rem_reg[k] <= rem_next[k];
            quo_reg[k] <= quo_next[k];
        end
    end

    assign u_valid = vld_reg[U_W-1];
    assign u_over  = ovr_reg[U_W-1];
    assign u       = quo_reg[U_W-1];

    a_u_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[U_W-1] && !ovr_reg[U_W-1] |-> quo_reg[U_W-1] <= U_ONE)
        else $error("normalized time above one");

endmodule

`default_nettype wire

[hdl/icq_coef.sv]
`default_nettype none

module icq_coef
    import icq_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic [V_W-1:0]  start_value,
    input  wire logic [V_W-1:0]  target_value,
    input  wire logic [V_W-1:0]  start_velocity,
    input  wire logic [T_W-1:0]  blend_time,
    output icq_coef_t            coef
);

    // stage 1: offset, velocity sign rule
    logic signed [X0_W-1:0] x0_next;
    logic [V_W-1:0]         v0_next;
    logic                   x0_pos, x0_neg, vi_pos, vi_neg;
    logic [X0_W-1:0]        x0_a_reg;
    logic [V_W-1:0]         v0_reg;

    assign x0_next = $signed({start_value[V_W-1], start_value})
                   - $signed({target_value[V_W-1], target_value});
    assign x0_neg  = x0_next[X0_W-1];
    assign x0_pos  = !x0_next[X0_W-1] && (x0_next != '0);
    assign vi_neg  = start_velocity[V_W-1];
    assign vi_pos  = !start_velocity[V_W-1] && (start_velocity != '0);
    assign v0_next = ((x0_pos && vi_pos) || (x0_neg && vi_neg)) ? '0 : start_velocity;

    // stage 2: v0 * T
    logic signed [2*V_W-1:0] prod_full;
    logic [PROD_W-1:0]       prod_reg;
    logic [X0_W-1:0]         x0_b_reg;
    logic                    vpos_b_reg, vneg_b_reg;

    assign prod_full = $signed(v0_reg) * $signed({1'b0, blend_time});

    // stage 3: w = v0*T truncated toward zero
    logic [PROD_W-1:0] prod_adj;
    logic [W_W-1:0]    w_c_reg;
    logic [X0_W-1:0]   x0_c_reg;
    logic              vpos_c_reg, vneg_c_reg;

    assign prod_adj = prod_reg + (prod_reg[PROD_W-1]
                    ? {{(PROD_W-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}} : '0);

    // stage 4: al = -8w - 20x0, cleared on same sign as v0
    logic signed [AL_W-1:0] w_al, x_al, al_raw;
    logic                   al_pos, al_neg;
    logic signed [AL_W-1:0] al_d_reg;
    logic [W_W-1:0]         w_d_reg;
    logic [X0_W-1:0]        x0_d_reg;
    logic                   vpos_d_reg, vneg_d_reg;

    assign w_al   = AL_W'($signed(w_c_reg));
    assign x_al   = AL_W'($signed(x0_c_reg));
    assign al_raw = -(w_al <<< 3) - (x_al <<< 4) - (x_al <<< 2);
    assign al_neg = al_raw[AL_W-1];
    assign al_pos = !al_raw[AL_W-1] && (al_raw != '0);

    // stage 5: scaled partials
    logic signed [COEF_W-1:0] ca, cw, cx;
    logic signed [COEF_W-1:0] a1_reg, a3_reg, w2_reg, w6_reg, w12_reg, w16_reg;
    logic signed [COEF_W-1:0] x12_reg, x20_reg, x30_reg;
    logic [X0_W-1:0]          x0_e_reg;

    assign ca = COEF_W'(al_d_reg);
    assign cw = COEF_W'($signed(w_d_reg));
    assign cx = COEF_W'($signed(x0_d_reg));

    // stage 6: coefficients of u .. u^5
    logic signed [COEF_W-1:0] c_next [NTERM];
    logic signed [COEF_W-1:0] c_reg  [NTERM];
    logic [X0_W-1:0]          x0_f_reg;

    assign c_next[0] = w2_reg;
    assign c_next[1] = a1_reg;
    assign c_next[2] = -(a3_reg + w12_reg + x20_reg);
    assign c_next[3] = a3_reg + w16_reg + x30_reg;
    assign c_next[4] = -(a1_reg + w6_reg + x12_reg);

    // stage 7: sign and magnitude
    icq_coef_t coef_next, coef_reg;

    always_comb
    begin
        logic signed [COEF_W-1:0] mag;
        mag = '0;
        coef_next.two_x0  = {x0_f_reg, 1'b0};
        coef_next.x0_zero = (x0_f_reg == '0);
        for (int i = 0; i < NTERM; i++)
        begin
            coef_next.neg[i] = c_reg[i][COEF_W-1];
            mag              = c_reg[i][COEF_W-1] ? -c_reg[i] : c_reg[i];
            coef_next.hi[i]  = mag[MAG_W-1:U_BITS];
            coef_next.lo[i]  = mag[U_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x0_a_reg   <= '0;
            v0_reg     <= '0;
            prod_reg   <= '0;
            x0_b_reg   <= '0;
            vpos_b_reg <= 1'b0;
            vneg_b_reg <= 1'b0;
            w_c_reg    <= '0;
            x0_c_reg   <= '0;
            vpos_c_reg <= 1'b0;
            vneg_c_reg <= 1'b0;
            al_d_reg   <= '0;
            w_d_reg    <= '0;
            x0_d_reg   <= '0;
            vpos_d_reg <= 1'b0;
            vneg_d_reg <= 1'b0;
            a1_reg     <= '0;
            a3_reg     <= '0;
            w2_reg     <= '0;
            w6_reg     <= '0;
            w12_reg    <= '0;
            w16_reg    <= '0;
            x12_reg    <= '0;
            x20_reg    <= '0;
            x30_reg    <= '0;
            x0_e_reg   <= '0;
            x0_f_reg   <= '0;
            for (int i = 0; i < NTERM; i++)
            begin
                c_reg[i] <= '0;
            end
            coef_reg   <= '0;
        end
        else
        begin
            x0_a_reg   <= x0_next;
            v0_reg     <= v0_next;
            prod_reg   <= prod_full[PROD_W-1:0];
            x0_b_reg   <= x0_a_reg;
            vpos_b_reg <= !v0_reg[V_W-1] && (v0_reg != '0);
            vneg_b_reg <= v0_reg[V_W-1];
            w_c_reg    <= prod_adj[PROD_W-1:FRAC_BITS];
            x0_c_reg   <= x0_b_reg;
            vpos_c_reg <= vpos_b_reg;
            vneg_c_reg <= vneg_b_reg;
            al_d_reg   <= ((vpos_c_reg && al_pos) || (vneg_c_reg && al_neg)) ? '0 : al_raw;
            w_d_reg    <= w_c_reg;
            x0_d_reg   <= x0_c_reg;
            vpos_d_reg <= vpos_c_reg;
            vneg_d_reg <= vneg_c_reg;
            a1_reg     <= ca;
            a3_reg     <= ca + (ca <<< 1);
            w2_reg     <= cw <<< 1;
            w6_reg     <= (cw <<< 2) + (cw <<< 1);
            w12_reg    <= (cw <<< 3) + (cw <<< 2);
            w16_reg    <= cw <<< 4;
            x12_reg    <= (cx <<< 3) + (cx <<< 2);
            x20_reg    <= (cx <<< 4) + (cx <<< 2);
            x30_reg    <= (cx <<< 5) - (cx <<< 1);
            x0_e_reg   <= x0_d_reg;
            x0_f_reg   <= x0_e_reg;
            for (int i = 0; i < NTERM; i++)
            begin
                c_reg[i] <= c_next[i];
            end
            coef_reg   <= coef_next;
        end
    end

    assign coef = coef_reg;

    a_al_sign: assert property (@(posedge clk) disable iff (!rst_n)
        !((vpos_d_reg && !al_d_reg[AL_W-1] && (al_d_reg != '0))
          || (vneg_d_reg && al_d_reg[AL_W-1])))
        else $error("acceleration kept with same sign as velocity");

    a_v0_sign: assert property (@(posedge clk) disable iff (!rst_n)
        !(vpos_b_reg && !x0_b_reg[X0_W-1] && (x0_b_reg != '0)))
        else $error("velocity kept with same sign as offset");

endmodule

`default_nettype wire

[hdl/icq_poly.sv]
`default_nettype none

module icq_poly
    import icq_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            u_valid,
    input  wire logic [U_W-1:0]  u,
    input  wire logic            u_over,
    input  wire icq_coef_t       coef,
    input  wire logic [V_W-1:0]  target_value,
    output logic                 done,
    output logic [V_W-1:0]       curve_value,
    output logic                 finished,
    output logic                 saturated
);

    localparam int NST = NPOW + 6;

    logic [NST-1:0] vld_reg;
    logic [NST-1:0] ovr_reg;

    // power stages: stage s adds u^(s+2)
    logic [NTERM-1:0][U_W-1:0] pw_reg  [NPOW];
    logic [NTERM-1:0][U_W-1:0] pw_next [NPOW];

    for (genvar s = 0; s < NPOW; s++) begin : g_pow
        logic [NTERM-1:0][U_W-1:0] src;
        logic [2*U_W-1:0]          sq;

        if (s == 0) begin : g_first
            assign src = {{((NTERM-1)*U_W){1'b0}}, u};
        end
        else begin : g_rest
            assign src = pw_reg[s-1];
        end

        assign sq = (2*U_W)'(src[s]) * (2*U_W)'(src[0]);

        always_comb
        begin
            pw_next[s]      = src;
            pw_next[s][s+1] = sq[U_BITS+U_W-1:U_BITS];
        end
    end

    // term products, split at the u fraction point
    logic [HP_W-1:0]          hp_next [NTERM];
    logic [HP_W-1:0]          hp_reg  [NTERM];
    logic [U_W-1:0]           lp_next [NTERM];
    logic [U_W-1:0]           lp_reg  [NTERM];
    logic signed [SUM_W-1:0]  term_next [NTERM];
    logic signed [SUM_W-1:0]  term_reg  [NTERM];

    always_comb
    begin
        logic [LPF_W-1:0]        lpf;
        logic [HP_W-1:0]         r;
        logic signed [SUM_W-1:0] rs;
        lpf = '0;
        r   = '0;
        rs  = '0;
        for (int i = 0; i < NTERM; i++)
        begin
            hp_next[i]   = HP_W'(coef.hi[i]) * HP_W'(pw_reg[NPOW-1][i]);
            lpf          = LPF_W'(coef.lo[i]) * LPF_W'(pw_reg[NPOW-1][i]);
            lp_next[i]   = lpf[LPF_W-1:U_BITS];
            r            = hp_reg[i] + HP_W'(lp_reg[i]);
            rs           = $signed(SUM_W'(r));
            term_next[i] = coef.neg[i] ? -rs : rs;
        end
    end

    logic signed [SUM_W-1:0] sa_reg, sb_reg, sc_reg, tot_reg, half_reg;
    logic signed [SUM_W-1:0] half_next, val;
    logic                    ovf, fin;
    logic [V_W-1:0]          value_next;
    logic                    done_reg, fin_reg, sat_reg;
    logic [V_W-1:0]          value_reg;

    // halve toward zero
    assign half_next = (tot_reg + $signed({{(SUM_W-1){1'b0}}, tot_reg[SUM_W-1]})) >>> 1;
    assign val       = half_reg + SUM_W'($signed(target_value));
    assign ovf       = val[SUM_W-1:V_W-1] != {(SUM_W-V_W+1){val[V_W-1]}};
    assign fin       = ovr_reg[NST-2] || coef.x0_zero;

    always_comb
    begin
        if (fin)
        begin
            value_next = target_value;
        end
        else if (ovf)
        begin
            value_next = val[SUM_W-1] ? VAL_MIN : VAL_MAX;
        end
        else
        begin
            value_next = val[V_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            ovr_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= {vld_reg[NST-2:0], u_valid};
            ovr_reg  <= {ovr_reg[NST-2:0], u_over};
            done_reg <= vld_reg[NST-2];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NPOW; k++)
        begin
            pw_reg[k] <= pw_next[k];
        end
        for (int i = 0; i < NTERM; i++)
        begin
            hp_reg[i]   <= hp_next[i];
            lp_reg[i]   <= lp_next[i];
            term_reg[i] <= term_next[i];
        end
        sa_reg    <= term_reg[0] + term_reg[1];
        sb_reg    <= term_reg[2] + term_reg[3];
        sc_reg    <= term_reg[4] + SUM_W'($signed(coef.two_x0));
        tot_reg   <= sa_reg + sb_reg + sc_reg;
        half_reg  <= half_next;
        value_reg <= value_next;
        fin_reg   <= fin;
        sat_reg   <= !fin && ovf;
    end

    assign done        = done_reg;
    assign curve_value = value_reg;
    assign finished    = fin_reg;
    assign saturated   = sat_reg;

    a_fin_nosat: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && fin_reg |-> !sat_reg)
        else $error("finished item flagged saturated");

    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && sat_reg |-> value_reg == VAL_MAX || value_reg == VAL_MIN)
        else $error("saturated item not at a limit");

endmodule

`default_nettype wire

[tb/sv/tb_inertialization_quintic_curve_top.sv]
`timescale 1ns / 100ps

module tb_inertialization_quintic_curve_top;
    import icq_pkg::*;

    localparam int PIPE_LAT = 41;
    localparam longint UF_ONE = 64'd1 << U_BITS;

    typedef struct packed {
        logic [V_W-1:0] value;
        logic           fin;
        logic           sat;
    } curve_res_t;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            psel = 1'b0;
    logic            penable = 1'b0;
    logic            pwrite = 1'b0;
    logic [3:0]      paddr = '0;
    logic [31:0]     pwdata = '0;
    logic [31:0]     prdata;
    logic            pready;
    logic            start = 1'b0;
    logic            busy;
    logic [T_W-1:0]  elapsed_time = '0;
    logic            done;
    logic [V_W-1:0]  curve_value;
    logic            finished;
    logic            saturated;

    // predictor copy of the registers
    logic [31:0]     cfg_start = '0;
    logic [31:0]     cfg_target = '0;
    logic [31:0]     cfg_velocity = '0;
    logic [T_W-1:0]  cfg_blend = BLEND_RESET;

    curve_res_t      expected_curve[$];
    int              n_items = 0;
    int              n_checked = 0;
    int              n_sat = 0;
    int              n_fin = 0;
    int              n_errors = 0;

    inertialization_quintic_curve_top u_top (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .busy(busy), .elapsed_time(elapsed_time),
        .done(done), .curve_value(curve_value), .finished(finished),
        .saturated(saturated)
    );

    always #2 clk = ~clk;

    function automatic int sign_of(longint x);
        return (x > 0) ? 1 : ((x < 0) ? -1 : 0);
    endfunction

    function automatic longint trunc_shr(longint x, int k);
        longint unsigned mag;
        mag = (x < 0) ? longint'(-x) : x;
        mag = mag >> k;
        return (x < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    // trunc(c * p / 2^U_BITS) without overflowing 64 bits
    function automatic longint scale_frac(longint c, longint unsigned p);
        longint unsigned mag, hi, lo, r;
        mag = (c < 0) ? longint'(-c) : c;
        hi = mag >> U_BITS;
        lo = mag & (UF_ONE - 1);
        r = hi * p + ((lo * p) >> U_BITS);
        return (c < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic curve_res_t curve_at(logic [T_W-1:0] t);
        curve_res_t res;
        longint tgt, x0, v0, w, al, total, val;
        longint unsigned bt, u, u2, u3, u4, u5;
        tgt = longint'(signed'(cfg_target));
        x0 = longint'(signed'(cfg_start)) - tgt;
        v0 = longint'(signed'(cfg_velocity));
        bt = cfg_blend;
        res.value = cfg_target;
        res.fin = 1'b1;
        res.sat = 1'b0;
        if (t > bt || bt == 0 || x0 == 0)
            return res;
        if (sign_of(x0) * sign_of(v0) > 0)
            v0 = 0;
        w = trunc_shr(v0 * longint'(bt), FRAC_BITS);
        al = -8 * w - 20 * x0;
        if (sign_of(v0) * sign_of(al) > 0)
            al = 0;
        u = (64'(t) << U_BITS) / bt;
        u2 = (u * u) >> U_BITS;
        u3 = (u2 * u) >> U_BITS;
        u4 = (u3 * u) >> U_BITS;
        u5 = (u4 * u) >> U_BITS;
        total = -scale_frac(al + 6 * w + 12 * x0, u5)
              + scale_frac(3 * al + 16 * w + 30 * x0, u4)
              - scale_frac(3 * al + 12 * w + 20 * x0, u3)
              + scale_frac(al, u2)
              + scale_frac(2 * w, u)
              + 2 * x0;
        val = tgt + trunc_shr(total, 1);
        res.fin = 1'b0;
        if (val > 64'sd2147483647) begin
            val = 64'sd2147483647;
            res.sat = 1'b1;
        end
        else if (val < -64'sd2147483648) begin
            val = -64'sd2147483648;
            res.sat = 1'b1;
        end
        res.value = val[31:0];
        return res;
    endfunction

    task automatic wait_idle();
        start <= 1'b0;
        while (expected_curve.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 4) @(posedge clk);
    endtask

    task automatic write_reg(icq_reg_t idx, logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 4'(idx) << 2;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_START:    cfg_start = data;
            REG_TARGET:   cfg_target = data;
            REG_VELOCITY: cfg_velocity = data;
            REG_BLEND:    cfg_blend = data[T_W-1:0];
            default:      ;
        endcase
    endtask

    task automatic load_curve(logic [31:0] s, logic [31:0] g, logic [31:0] v,
                              logic [T_W-1:0] bt);
        wait_idle();
        write_reg(REG_START, s);
        write_reg(REG_TARGET, g);
        write_reg(REG_VELOCITY, v);
        write_reg(REG_BLEND, 32'(bt));
        // coefficients settle after the write
        repeat (10) @(posedge clk);
    endtask

    task automatic send_time(logic [T_W-1:0] t);
        int gap;
        gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        elapsed_time <= t;
        forever begin
            @(negedge clk);
            if (!busy)
                break;
        end
        @(posedge clk);
        expected_curve.push_back(curve_at(t));
        n_items++;
    endtask

    function automatic logic [T_W-1:0] pick_time();
        case ($urandom_range(0, 9))
            0:       return T_W'($urandom());
            1:       return cfg_blend;
            2:       return (cfg_blend == '1) ? cfg_blend : cfg_blend + T_W'(1);
            3:       return '0;
            default: return T_W'($urandom_range(0, cfg_blend));
        endcase
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'(signed'($urandom_range(0, 400000)) - 200000);
            3:       return 32'd0;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [T_W-1:0] pick_blend();
        case ($urandom_range(0, 5))
            0:       return T_W'(1);
            1:       return '1;
            2:       return T_W'($urandom_range(1, 64));
            3:       return T_W'($urandom_range(1, 32'h0004_0000));
            default: return T_W'($urandom()) | 1'b1;
        endcase
    endfunction

    task automatic test_reset_state();
        send_time(0);
        send_time(BLEND_RESET);
        send_time('1);
    endtask

    task automatic test_directed();
        logic [31:0] s;
        // ordinary decay, velocity toward and away from target
        load_curve(32'h0001_0000, 32'h0000_0000, 32'hFFFF_8000, BLEND_RESET);
        send_time(0);
        send_time(BLEND_RESET >> 1);
        send_time(BLEND_RESET);
        send_time(BLEND_RESET + T_W'(1));
        send_time('1);
        load_curve(32'hFFFF_0000, 32'h0002_0000, 32'hFFF0_0000, BLEND_RESET);
        send_time(BLEND_RESET >> 2);
        send_time(BLEND_RESET - T_W'(1));
        // zero offset
        load_curve(32'h1234_5678, 32'h1234_5678, 32'h0100_0000, BLEND_RESET);
        send_time(0);
        send_time(100);
        // zero blend time
        s = 32'h0003_0000;
        load_curve(s, 32'h0, 32'h0, 0);
        send_time(0);
        send_time(5);
        // extremes, both clamp directions
        load_curve(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, '1);
        send_time(1);
        send_time(T_W'(1) << 29);
        send_time('1);
        load_curve(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, '1);
        send_time(T_W'(1) << 28);
        send_time({T_W{1'b1}} - T_W'(1));
        load_curve(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1);
        send_time(0);
        send_time(1);
        send_time(2);
    endtask

    task automatic test_random_curves();
        for (int ph = 0; ph < 28; ph++) begin
            load_curve(pick_value(), pick_value(), pick_value(), pick_blend());
            for (int k = 0; k < 29; k++)
                send_time(pick_time());
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && done) begin
            if (expected_curve.size() == 0) begin
                $error("result with nothing expected: curve_value %h", curve_value);
                n_errors++;
            end
            else begin
                curve_res_t exp_r;
                exp_r = expected_curve.pop_front();
                n_checked++;
                if (exp_r.sat) n_sat++;
                if (exp_r.fin) n_fin++;
                if (curve_value !== exp_r.value) begin
                    $error("curve_value expected %h actual %h", exp_r.value, curve_value);
                    n_errors++;
                end
                if (finished !== exp_r.fin) begin
                    $error("finished expected %b actual %b", exp_r.fin, finished);
                    n_errors++;
                end
                if (saturated !== exp_r.sat) begin
                    $error("saturated expected %b actual %b", exp_r.sat, saturated);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_reset_state();
        test_directed();
        test_random_curves();
        wait_idle();
        $display("%0d items sent over the reset curve and 35 loaded curves; %0d checked",
                 n_items, n_checked);
        $display("%0d finished and %0d clamped results among them", n_fin, n_sat);
        if (n_errors == 0 && expected_curve.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #4ms;
        $display("timeout");
        $display("*** FAILED ***");
        $finish;
    end

endmodule

[sim.f]
hdl/icq_pkg.sv
hdl/icq_div.sv
hdl/icq_coef.sv
hdl/icq_poly.sv
hdl/inertialization_quintic_curve_top.sv
tb/sv/tb_inertialization_quintic_curve_top.sv
